// ===== hdl/spi_master_shift_controller_core_assert.svh =====
// assertion macros for the spi master shift controller core
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SPI_MASTER_SHIFT_CONTROLLER_CORE_ASSERT_SVH
`define SPI_MASTER_SHIFT_CONTROLLER_CORE_ASSERT_SVH

// property holds in the same cycle
`define SPIMSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SPIMSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/spimsc_pkg.sv =====
// shared constants, types and helpers of the spi master shift controller
// no dependencies
package spimsc_pkg;

  // sizes
  localparam int unsigned SHIFT_BITS = 128;
  localparam int unsigned SEL_COUNT  = 8;
  localparam int unsigned DIV_BITS   = 16;
  localparam int unsigned PTR_W      = $clog2(SHIFT_BITS);
  localparam int unsigned CNT_W      = $clog2(SHIFT_BITS + 1);
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned WORD_SEL_W = 2;
  localparam int unsigned WORD_COUNT = 4;
  localparam int unsigned EXT_BITS   = WORD_W * WORD_COUNT;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned FULL_W     = 8;
  localparam int unsigned ADDR_W     = 5;

  localparam logic [FULL_W-1:0]   MAX_LEN   = FULL_W'(128);
  localparam logic [DIV_BITS-1:0] DIV_RESET = DIV_BITS'(32'h0000ffff);
  localparam logic [WORD_W-1:0]   DIV_MASK  = 32'h0000ffff;

  // bus operations
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // register map of the item side
  localparam logic [2:0] REG_DATA0 = 3'd0;
  localparam logic [2:0] REG_DATA1 = 3'd1;
  localparam logic [2:0] REG_DATA2 = 3'd2;
  localparam logic [2:0] REG_DATA3 = 3'd3;
  localparam logic [2:0] REG_CTRL  = 3'd4;
  localparam logic [2:0] REG_SEL   = 3'd5;

  // configuration register map
  localparam logic [2:0] CFG_DIV   = 3'd0;
  localparam logic [2:0] CFG_LSB   = 3'd1;
  localparam logic [2:0] CFG_TXNEG = 3'd2;
  localparam logic [2:0] CFG_RXNEG = 3'd3;
  localparam logic [2:0] CFG_IE    = 3'd4;
  localparam logic [2:0] CFG_ASS   = 3'd5;

  // control register bits
  localparam int unsigned CR_GO       = 8;
  localparam int unsigned CR_BUSY     = 8;
  localparam int unsigned CR_RXFALL   = 9;
  localparam int unsigned CR_TXFALL   = 10;
  localparam int unsigned CR_LSBFIRST = 11;
  localparam int unsigned CR_IRQEN    = 12;
  localparam int unsigned CR_AUTOSEL  = 13;

  // requests from the sequencer to the data register
  typedef struct packed {
    logic                  word_we;
    logic [WORD_SEL_W-1:0] word_sel;
    logic [WORD_W-1:0]     word_data;
    logic                  bit_we;
    logic [PTR_W-1:0]      bit_pos;
    logic                  bit_val;
    logic [PTR_W-1:0]      tx_pos;
  } shift_ctrl_t;

  // zero means the full 128 bits, clamped to the register size
  function automatic logic [CNT_W-1:0] eff_length(input logic [LEN_W-1:0] len);
    logic [FULL_W-1:0] full;
    full = (len == '0) ? MAX_LEN : FULL_W'(len);
    if (full > FULL_W'(SHIFT_BITS)) full = FULL_W'(SHIFT_BITS);
    return CNT_W'(full);
  endfunction

endpackage

// ===== hdl/spimsc_shift.sv =====
// data register of the spi master, word access from the bus side
// and single received bits from the serial side; uses spimsc_pkg
module spimsc_shift (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  spimsc_pkg::shift_ctrl_t    ctrl_i,
  output logic [spimsc_pkg::WORD_W-1:0] word_o,
  output logic                       tx_bit_o
);
  import spimsc_pkg::*;

  logic [SHIFT_BITS-1:0] data_q, data_d;
  logic [EXT_BITS-1:0]   data_ext;
  logic [EXT_BITS-1:0]   wr_ext;

  // word view, bits beyond the register read as zero
  always_comb begin
    data_ext                 = '0;
    data_ext[SHIFT_BITS-1:0] = data_q;
    word_o                   = data_ext[ctrl_i.word_sel * WORD_W +: WORD_W];
    tx_bit_o                 = data_q[ctrl_i.tx_pos];
  end

  // word write from the bus or one received bit in place
  always_comb begin
    data_d = data_q;
    wr_ext = data_ext;
    if (ctrl_i.word_we) begin
      wr_ext[ctrl_i.word_sel * WORD_W +: WORD_W] = ctrl_i.word_data;
      data_d = wr_ext[SHIFT_BITS-1:0];
    end else if (ctrl_i.bit_we) begin
      data_d[ctrl_i.bit_pos] = ctrl_i.bit_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

endmodule

// ===== hdl/spi_master_shift_controller_core.sv =====
// SPI master with a 128-bit data register behind a small register file. Each
// input transfer is one system tick or one register access; its result (read
// data and the status lines after the step) appears in the output register
// on the next clock, and a new item is taken in every cycle unless that
// output register is full and stalled, so the sustained rate is one item per
// clock. The serial side moves the data bits through a bit pointer into the
// data register; SCLK toggles every clock_divider+1 ticks. Configuration sits
// behind an APB-style port.
// depends on spimsc_pkg, spimsc_shift and the assertion macro header
`include "spi_master_shift_controller_core_assert.svh"

module spi_master_shift_controller_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     op_i,
  input  logic [2:0]                     reg_index_i,
  input  logic [31:0]                    write_value_i,
  input  logic                           miso_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [31:0]                    read_value_o,
  output logic                           busy_res_o,
  output logic                           irq_o,
  output logic                           sclk_o,
  output logic                           mosi_o,
  output logic [7:0]                     select_out_o,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [spimsc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import spimsc_pkg::*;

  // configuration registers
  logic [DIV_BITS-1:0] cfg_div_q;
  logic cfg_lsb_q, cfg_txneg_q, cfg_rxneg_q, cfg_ie_q, cfg_ass_q;
  logic cfg_wr;

  // controller state
  logic [CNT_W-1:0]     bits_left_q, bits_left_d;
  logic [LEN_W-1:0]     char_len_q, char_len_d;
  logic [DIV_BITS-1:0]  tick_q, tick_d;
  logic                 sclk_q, sclk_d;
  logic                 busy_q, busy_d;
  logic                 irq_q, irq_d;
  logic                 mosi_q, mosi_d;
  logic [SEL_COUNT-1:0] sel_q, sel_d;

  // output register
  logic        out_valid_q;
  logic [31:0] rd_q;
  logic        busy_res_q, irq_res_q, sclk_res_q, mosi_res_q;
  logic [7:0]  sel_res_q;

  // step logic
  logic              in_acc;
  logic [CNT_W-1:0]  eff_len, k_idx, go_len;
  logic [PTR_W-1:0]  pos_k, pos_k1, go_pos;
  logic              tick_hit, go;
  logic [WORD_W-1:0] rd_val, ctrl_rd, word_rd;
  logic              tx_bit;
  shift_ctrl_t       sctl;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_div_q   <= DIV_RESET;
      cfg_lsb_q   <= 1'b0;
      cfg_txneg_q <= 1'b0;
      cfg_rxneg_q <= 1'b0;
      cfg_ie_q    <= 1'b0;
      cfg_ass_q   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        CFG_DIV:   cfg_div_q   <= DIV_BITS'(pwdata & DIV_MASK);
        CFG_LSB:   cfg_lsb_q   <= pwdata[0];
        CFG_TXNEG: cfg_txneg_q <= pwdata[0];
        CFG_RXNEG: cfg_rxneg_q <= pwdata[0];
        CFG_IE:    cfg_ie_q    <= pwdata[0];
        CFG_ASS:   cfg_ass_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // configuration read back
  always_comb begin
    unique case (paddr[4:2])
      CFG_DIV:   prdata = 32'(cfg_div_q);
      CFG_LSB:   prdata = 32'(cfg_lsb_q);
      CFG_TXNEG: prdata = 32'(cfg_txneg_q);
      CFG_RXNEG: prdata = 32'(cfg_rxneg_q);
      CFG_IE:    prdata = 32'(cfg_ie_q);
      CFG_ASS:   prdata = 32'(cfg_ass_q);
      default:   prdata = '0;
    endcase
  end

  // handshake: one output stage
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;

  // bit positions of the current and the next serial bit
  always_comb begin
    eff_len = eff_length(char_len_q);
    k_idx   = eff_len - bits_left_q;
    pos_k   = cfg_lsb_q ? PTR_W'(k_idx) : PTR_W'(eff_len - k_idx - CNT_W'(1));
    pos_k1  = cfg_lsb_q ? PTR_W'(k_idx + CNT_W'(1)) : PTR_W'(eff_len - k_idx - CNT_W'(2));
    go_len  = eff_length(write_value_i[LEN_W-1:0]);
    go_pos  = cfg_lsb_q ? '0 : PTR_W'(go_len - CNT_W'(1));
  end

  assign tick_hit = busy_q && (tick_q >= cfg_div_q);
  assign go = (reg_index_i == REG_CTRL) && !busy_q && write_value_i[CR_GO];

  // control register image
  always_comb begin
    ctrl_rd              = '0;
    ctrl_rd[LEN_W-1:0]   = char_len_q;
    ctrl_rd[CR_BUSY]     = busy_q;
    ctrl_rd[CR_RXFALL]   = cfg_rxneg_q;
    ctrl_rd[CR_TXFALL]   = cfg_txneg_q;
    ctrl_rd[CR_LSBFIRST] = cfg_lsb_q;
    ctrl_rd[CR_IRQEN]    = cfg_ie_q;
    ctrl_rd[CR_AUTOSEL]  = cfg_ass_q;
  end

  // data register access requests
  always_comb begin
    sctl.word_we   = 1'b0;
    sctl.word_sel  = reg_index_i[WORD_SEL_W-1:0];
    sctl.word_data = write_value_i;
    sctl.bit_we    = 1'b0;
    sctl.bit_pos   = pos_k;
    sctl.bit_val   = miso_i;
    if (op_i == OP_WRITE && go) begin
      sctl.tx_pos = go_pos;
    end else if (sclk_q) begin
      sctl.tx_pos = pos_k1;
    end else begin
      sctl.tx_pos = pos_k;
    end
    if (in_acc && op_i == OP_WRITE && reg_index_i < REG_CTRL && !busy_q) begin
      sctl.word_we = 1'b1;
    end
    if (in_acc && op_i == OP_TICK && tick_hit) begin
      sctl.bit_we = sclk_q ? cfg_rxneg_q : !cfg_rxneg_q;
    end
  end

  spimsc_shift u_shift (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (sctl),
    .word_o   (word_rd),
    .tx_bit_o (tx_bit)
  );

  // next state for one item
  always_comb begin
    bits_left_d = bits_left_q;
    char_len_d  = char_len_q;
    tick_d      = tick_q;
    sclk_d      = sclk_q;
    busy_d      = busy_q;
    irq_d       = irq_q;
    mosi_d      = mosi_q;
    sel_d       = sel_q;
    rd_val      = '0;
    if (in_acc) begin
      unique case (op_i)
        OP_TICK: begin
          if (!busy_q) begin
            tick_d = '0;
          end else if (tick_hit) begin
            tick_d = '0;
            if (!sclk_q) begin
              // rising edge
              sclk_d = 1'b1;
              if (!cfg_txneg_q) mosi_d = tx_bit;
            end else begin
              // falling edge, one bit done
              sclk_d = 1'b0;
              if (cfg_txneg_q && bits_left_q > CNT_W'(1)) mosi_d = tx_bit;
              bits_left_d = bits_left_q - CNT_W'(1);
              if (bits_left_q == CNT_W'(1)) begin
                busy_d = 1'b0;
                if (cfg_ie_q) irq_d = 1'b1;
              end
            end
          end else begin
            tick_d = tick_q + DIV_BITS'(1);
          end
        end
        OP_READ: begin
          irq_d = 1'b0;
          if (reg_index_i < REG_CTRL) begin
            rd_val = word_rd;
          end else if (reg_index_i == REG_CTRL) begin
            rd_val = ctrl_rd;
          end else if (reg_index_i == REG_SEL) begin
            rd_val = 32'(sel_q);
          end
        end
        OP_WRITE: begin
          irq_d = 1'b0;
          if (reg_index_i == REG_CTRL && !busy_q) begin
            char_len_d = write_value_i[LEN_W-1:0];
            if (go) begin
              busy_d      = 1'b1;
              bits_left_d = go_len;
              tick_d      = '0;
              sclk_d      = 1'b0;
              mosi_d      = tx_bit;
            end
          end else if (reg_index_i == REG_SEL) begin
            sel_d = SEL_COUNT'(write_value_i);
          end
        end
        default: ;
      endcase
    end
  end

  // controller state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_left_q <= '0;
      char_len_q  <= '0;
      tick_q      <= '0;
      sclk_q      <= 1'b0;
      busy_q      <= 1'b0;
      irq_q       <= 1'b0;
      mosi_q      <= 1'b0;
      sel_q       <= '0;
    end else begin
      bits_left_q <= bits_left_d;
      char_len_q  <= char_len_d;
      tick_q      <= tick_d;
      sclk_q      <= sclk_d;
      busy_q      <= busy_d;
      irq_q       <= irq_d;
      mosi_q      <= mosi_d;
      sel_q       <= sel_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded on each accepted item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q       <= rd_val;
      busy_res_q <= busy_d;
      irq_res_q  <= irq_d;
      sclk_res_q <= sclk_d;
      mosi_res_q <= mosi_d;
      sel_res_q  <= (cfg_ass_q && !busy_d) ? '0 : 8'(sel_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = rd_q;
  assign busy_res_o   = busy_res_q;
  assign irq_o        = irq_res_q;
  assign sclk_o       = sclk_res_q;
  assign mosi_o       = mosi_res_q;
  assign select_out_o = sel_res_q;

  // checks
  `SPIMSC_ASSERT(a_busy_bits, !busy_q || (bits_left_q != '0), "busy with no bits left")
  `SPIMSC_ASSERT(a_idle_quiet, busy_q || (tick_q == '0 && !sclk_q), "idle but sclk running")
  `SPIMSC_ASSERT_NEXT(a_done_on_tick, busy_q && !busy_d,
                      $past(in_acc) && $past(op_i) == OP_TICK, "ended off a tick")
  `SPIMSC_ASSERT_NEXT(a_irq_enabled, !irq_q && irq_d, $past(cfg_ie_q), "irq while disabled")

endmodule

// ===== verif/spimsc_status_checker.sv =====
`timescale 1ns / 100ps
// result checker for the spi master shift controller core: follows the item,
// result and configuration ports, predicts the status after every item and
// compares each result on arrival; depends on spimsc_pkg
module spimsc_status_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item channel as seen on the core
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [1:0]                    op_i,
  input  logic [2:0]                    reg_index_i,
  input  logic [31:0]                   write_value_i,
  input  logic                          miso_i,
  // result channel as seen on the core
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [31:0]                   read_value_i,
  input  logic                          busy_res_i,
  input  logic                          irq_i,
  input  logic                          sclk_i,
  input  logic                          mosi_i,
  input  logic [7:0]                    select_out_i,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spimsc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  // to the testbench top
  output int                            mismatches_o,
  output int                            awaiting_o
);
  import spimsc_pkg::*;

  typedef struct packed {
    logic [31:0] read_value;
    logic        busy;
    logic        irq;
    logic        sclk;
    logic        mosi;
    logic [7:0]  select;
  } spi_status_t;

  // predicted controller state
  logic [SHIFT_BITS-1:0] shift_reg;
  logic [7:0]            bits_left;
  logic [LEN_W-1:0]      char_len;
  logic [DIV_BITS-1:0]   div_cnt;
  logic                  sclk_q, busy_q, irq_q, mosi_q;
  logic [7:0]            sel_q;

  // predicted configuration
  logic [DIV_BITS-1:0]   cfg_div;
  logic                  cfg_lsb, cfg_txneg, cfg_rxneg, cfg_ie, cfg_ass;

  spi_status_t           expected_status[$];

  // bits in the frame, zero standing for the full register
  function automatic int unsigned frame_bits();
    int unsigned len;
    len = (char_len == '0) ? 128 : int'(char_len);
    if (len > SHIFT_BITS) len = SHIFT_BITS;
    return len;
  endfunction

  // data position of the k-th bit on the wire
  function automatic int unsigned wire_slot(input int unsigned k);
    int unsigned len, n;
    len = frame_bits();
    n = (k >= len) ? len - 1 : k;
    return cfg_lsb ? n : len - 1 - n;
  endfunction

  // one sclk toggle: drive mosi and sample miso on the chosen edges
  function automatic void sclk_toggle(input logic miso);
    int unsigned len, k;
    len = frame_bits();
    k = len - int'(bits_left);
    if (!sclk_q) begin
      sclk_q = 1'b1;
      if (!cfg_txneg) mosi_q = shift_reg[wire_slot(k)];
      if (!cfg_rxneg) shift_reg[wire_slot(k)] = miso;
    end else begin
      sclk_q = 1'b0;
      if (cfg_txneg && (k + 1 < len)) mosi_q = shift_reg[wire_slot(k + 1)];
      if (cfg_rxneg) shift_reg[wire_slot(k)] = miso;
      bits_left = bits_left - 8'd1;
      if (bits_left == 8'd0) begin
        busy_q = 1'b0;
        if (cfg_ie) irq_q = 1'b1;
      end
    end
  endfunction

  // status after one item
  function automatic spi_status_t advance_controller(input logic [1:0] op,
                                                     input logic [2:0] idx,
                                                     input logic [31:0] val,
                                                     input logic miso);
    spi_status_t st;
    logic [31:0] rd;
    int unsigned w;
    rd = '0;
    w  = int'(idx);
    case (op)
      OP_TICK: begin
        if (!busy_q) begin
          div_cnt = '0;
        end else if (div_cnt >= cfg_div) begin
          div_cnt = '0;
          sclk_toggle(miso);
        end else begin
          div_cnt = div_cnt + 1'b1;
        end
      end
      OP_READ: begin
        irq_q = 1'b0;
        if (w < WORD_COUNT) begin
          rd = shift_reg[w*WORD_W +: WORD_W];
        end else if (idx == REG_CTRL) begin
          rd = 32'(char_len);
          rd[CR_BUSY]     = busy_q;
          rd[CR_RXFALL]   = cfg_rxneg;
          rd[CR_TXFALL]   = cfg_txneg;
          rd[CR_LSBFIRST] = cfg_lsb;
          rd[CR_IRQEN]    = cfg_ie;
          rd[CR_AUTOSEL]  = cfg_ass;
        end else if (idx == REG_SEL) begin
          rd = 32'(sel_q);
        end
      end
      OP_WRITE: begin
        irq_q = 1'b0;
        if (w < WORD_COUNT) begin
          if (!busy_q) shift_reg[w*WORD_W +: WORD_W] = val;
        end else if (idx == REG_CTRL) begin
          if (!busy_q) begin
            char_len = val[LEN_W-1:0];
            if (val[CR_GO]) begin
              busy_q    = 1'b1;
              bits_left = 8'(frame_bits());
              div_cnt   = '0;
              sclk_q    = 1'b0;
              mosi_q    = shift_reg[wire_slot(0)];
            end
          end
        end else if (idx == REG_SEL) begin
          sel_q = val[7:0];
        end
      end
      default: ;
    endcase
    st.read_value = rd;
    st.busy       = busy_q;
    st.irq        = irq_q;
    st.sclk       = sclk_q;
    st.mosi       = mosi_q;
    st.select     = (cfg_ass && !busy_q) ? 8'd0 : sel_q;
    return st;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches_o++;
    end
  endtask

  // follow configuration writes, item transfers and result transfers
  always @(posedge clk_i or negedge rst_ni) begin
    spi_status_t want;
    if (!rst_ni) begin
      shift_reg = '0;
      bits_left = '0;
      char_len  = '0;
      div_cnt   = '0;
      sclk_q    = 1'b0;
      busy_q    = 1'b0;
      irq_q     = 1'b0;
      mosi_q    = 1'b0;
      sel_q     = '0;
      cfg_div   = DIV_RESET;
      cfg_lsb   = 1'b0;
      cfg_txneg = 1'b0;
      cfg_rxneg = 1'b0;
      cfg_ie    = 1'b0;
      cfg_ass   = 1'b0;
      expected_status.delete();
      mismatches_o = 0;
      awaiting_o   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          CFG_DIV:   cfg_div   = pwdata[DIV_BITS-1:0];
          CFG_LSB:   cfg_lsb   = pwdata[0];
          CFG_TXNEG: cfg_txneg = pwdata[0];
          CFG_RXNEG: cfg_rxneg = pwdata[0];
          CFG_IE:    cfg_ie    = pwdata[0];
          CFG_ASS:   cfg_ass   = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        expected_status.push_back(advance_controller(op_i, reg_index_i,
                                                     write_value_i, miso_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_status.size() == 0) begin
          $error("result transfer with no expected result waiting");
          mismatches_o++;
        end else begin
          want = expected_status.pop_front();
          check_field("read_value", want.read_value, read_value_i);
          check_field("busy_res", 32'(want.busy), 32'(busy_res_i));
          check_field("irq", 32'(want.irq), 32'(irq_i));
          check_field("sclk", 32'(want.sclk), 32'(sclk_i));
          check_field("mosi", 32'(want.mosi), 32'(mosi_i));
          check_field("select_out", 32'(want.select), 32'(select_out_i));
        end
      end
      awaiting_o = expected_status.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// testbench top for the spi master shift controller core: clock, reset,
// configuration writes, item stimulus, receiver stalls and the verdict
// depends on spimsc_pkg, spimsc_status_checker and the core
module tb;
  import spimsc_pkg::*;

  localparam logic [1:0] OP_NONE     = 2'd3;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam int         HOLD_CYCLES = 60;
  localparam int         ANY_LEN     = -1;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic              clk_i, rst_ni;
  logic              in_valid_i, in_stall_o;
  logic [1:0]        op_i;
  logic [2:0]        reg_index_i;
  logic [31:0]       write_value_i;
  logic              miso_i;
  logic              out_valid_o, out_stall_i;
  logic [31:0]       read_value_o;
  logic              busy_res_o, irq_o, sclk_o, mosi_o;
  logic [7:0]        select_out_o;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata, prdata;

  int mismatch_count, awaiting;
  int burst_left, items_sent, hold_orders, cur_div;

  spi_master_shift_controller_core DUT (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .op_i, .reg_index_i, .write_value_i, .miso_i,
    .out_valid_o, .out_stall_i, .read_value_o, .busy_res_o, .irq_o, .sclk_o,
    .mosi_o, .select_out_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  spimsc_status_checker status_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .op_i, .reg_index_i, .write_value_i,
    .miso_i,
    .out_valid_i(out_valid_o), .out_stall_i, .read_value_i(read_value_o),
    .busy_res_i(busy_res_o), .irq_i(irq_o), .sclk_i(sclk_o), .mosi_i(mosi_o),
    .select_out_i(select_out_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches_o(mismatch_count), .awaiting_o(awaiting)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

  // data word values, leaning on the extremes
  function automatic logic [31:0] data_pattern();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 32'h0;
    if (pick == 1) return 32'hffff_ffff;
    return $urandom;
  endfunction

  // one item transfer, sent in bursts with random gaps between them
  task automatic send_item(input logic [1:0] op, input logic [2:0] idx,
                           input logic [31:0] val, input logic miso);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, ($urandom_range(0, 2) == 0) ? 40 : 10);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    reg_index_i   <= idx;
    write_value_i <= val;
    miso_i        <= miso;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  // pause the sender until every predicted result has come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (awaiting != 0);
  endtask

  // setup phase and access phase, then idle
  task automatic cfg_write(input logic [2:0] cfg_reg, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({cfg_reg, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_config(input int div, input bit lsb, input bit txneg,
                              input bit rxneg, input bit ie, input bit ass);
    wait_for_results();
    cfg_write(CFG_DIV, 32'(div));
    cfg_write(CFG_LSB, 32'(lsb));
    cfg_write(CFG_TXNEG, 32'(txneg));
    cfg_write(CFG_RXNEG, 32'(rxneg));
    cfg_write(CFG_IE, 32'(ie));
    cfg_write(CFG_ASS, 32'(ass));
    cur_div = div;
  endtask

  // register traffic while a frame is shifting
  task automatic busy_access(input bit early);
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: send_item(OP_READ, 3'($urandom_range(0, 7)), $urandom, 1'($urandom));
      1: send_item(OP_WRITE, 3'($urandom_range(0, WORD_COUNT - 1)), data_pattern(),
                   1'($urandom));
      2: send_item(OP_WRITE, REG_SEL, $urandom, 1'($urandom));
      default: begin
        v = $urandom;
        if (early) send_item(OP_WRITE, REG_CTRL, v, 1'($urandom));
        else send_item(OP_READ, REG_CTRL, v, 1'($urandom));
      end
    endcase
  endtask

  // load, start, clock out and read back one frame
  task automatic spi_frame(input int forced_len, input int tick_cap);
    int len, nbits, nticks;
    logic [31:0] v;
    for (int w = 0; w < WORD_COUNT; w++) begin
      if ($urandom_range(0, 3) != 0)
        send_item(OP_WRITE, 3'(w), data_pattern(), 1'($urandom));
    end
    if ($urandom_range(0, 2) == 0) send_item(OP_WRITE, REG_SEL, $urandom, 1'($urandom));
    if (forced_len >= 0) len = forced_len;
    else if (cur_div == 0 && $urandom_range(0, 15) == 0) len = $urandom_range(17, 48);
    else len = $urandom_range(1, 16);
    v = $urandom;
    v[LEN_W-1:0] = LEN_W'(len);
    v[CR_GO] = 1'b1;
    send_item(OP_WRITE, REG_CTRL, v, 1'($urandom));
    nbits = (len == 0) ? 128 : len;
    nticks = 2 * nbits * (cur_div + 1) + $urandom_range(0, 3);
    if (nticks > tick_cap) nticks = tick_cap;
    for (int i = 0; i < nticks; i++) begin
      if ($urandom_range(0, 7) == 0) busy_access(i < nticks / 2);
      send_item(OP_TICK, 3'($urandom_range(0, 7)), $urandom, 1'($urandom));
    end
    if ($urandom_range(0, 1) == 0) send_item(OP_READ, REG_CTRL, $urandom, 1'($urandom));
    for (int w = 0; w < WORD_COUNT; w++) send_item(OP_READ, 3'(w), $urandom, 1'($urandom));
  endtask

  // mostly well-formed frames, the rest random items of any kind
  task automatic run_phase(input int budget, input int forced_len, input int tick_cap);
    int start;
    bit first;
    start = items_sent;
    first = 1'b1;
    while (items_sent - start < budget) begin
      if (first || $urandom_range(0, 3) != 0) begin
        spi_frame(first ? forced_len : ANY_LEN, tick_cap);
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), data_pattern(),
                    1'($urandom));
      end
      first = 1'b0;
    end
  endtask

  // receiver stalls: changing patterns, plus long hold-offs on request
  initial begin
    stall_mode_t mode;
    int mode_left, cycle_cnt, holds_done;
    out_stall_i = 1'b0;
    mode = STALL_NONE;
    mode_left = 0;
    cycle_cnt = 0;
    holds_done = 0;
    forever begin
      @(negedge clk_i);
      if (holds_done != hold_orders) begin
        holds_done++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        cycle_cnt++;
        case (mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= ((cycle_cnt % 5) < 2);
        endcase
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [31:0] v;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = OP_TICK;
    reg_index_i   = '0;
    write_value_i = '0;
    miso_i        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    burst_left    = 0;
    items_sent    = 0;
    hold_orders   = 0;
    cur_div       = 65535;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset contents, all-ones and all-zero words, spare indexes,
    // unused op, idle ticks, control write without go
    for (int r = 0; r < 8; r++) send_item(OP_READ, 3'(r), '1, 1'b1);
    send_item(OP_WRITE, REG_DATA0, 32'hffff_ffff, 1'b0);
    send_item(OP_WRITE, REG_DATA1, 32'h0, 1'b1);
    send_item(OP_WRITE, REG_DATA2, 32'h5a5a_a5a5, 1'b0);
    send_item(OP_WRITE, REG_DATA3, 32'hffff_ffff, 1'b1);
    send_item(OP_WRITE, REG_SEL, 32'hffff_ffff, 1'b0);
    send_item(OP_WRITE, REG_SPARE_A, 32'hffff_ffff, 1'b1);
    send_item(OP_WRITE, REG_SPARE_B, 32'hffff_ffff, 1'b0);
    send_item(OP_NONE, REG_SPARE_B, 32'hffff_ffff, 1'b1);
    send_item(OP_TICK, REG_DATA0, 32'h0, 1'b1);
    send_item(OP_TICK, REG_SPARE_B, 32'hffff_ffff, 1'b0);
    v = '1;
    v[CR_GO] = 1'b0;
    send_item(OP_WRITE, REG_CTRL, v, 1'b1);
    send_item(OP_READ, REG_CTRL, 32'h0, 1'b0);
    send_item(OP_READ, REG_DATA3, 32'h0, 1'b1);
    send_item(OP_READ, REG_SEL, 32'h0, 1'b0);
    send_item(OP_READ, REG_SPARE_A, 32'h0, 1'b1);

    // fixed settings first: full-length frame, all flags but the interrupt
    // enable set with a long receiver hold-off, mixed edges, and a 127-bit frame
    apply_config(0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    run_phase(100, 0, 1000);
    apply_config(1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
    hold_orders++;
    run_phase(60, ANY_LEN, 1000);
    apply_config(2, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
    run_phase(60, ANY_LEN, 1000);
    apply_config(0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
    run_phase(100, 127, 1000);

    // random settings
    for (int p = 0; p < 4; p++) begin
      apply_config($urandom_range(0, 3), 1'($urandom), 1'($urandom), 1'($urandom),
                   1'($urandom), 1'($urandom));
      if (p == 2) hold_orders++;
      run_phase(40, ANY_LEN, 1000);
    end

    // slowest divider: frames start but only a few ticks are given
    apply_config(65535, 1'($urandom), 1'($urandom), 1'($urandom), 1'b1, 1'($urandom));
    run_phase(30, ANY_LEN, 20);

    wait_for_results();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/spimsc_pkg.sv
hdl/spimsc_shift.sv
hdl/spi_master_shift_controller_core.sv
verif/spimsc_status_checker.sv
verif/tb.sv
